// ===== src/rlw_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotor link watchdog package
// Shared types and constants: outcome codes, register indexes, the
// configuration bundle and the layout of one channel entry.
// ----------------------------------------------------------------------------
package rlw_pkg;

   // Widths of the fixed fields.
   localparam int unsigned CHANNEL_W = 8;
   localparam int unsigned STAMP_W   = 63;
   localparam int unsigned OUTCOME_W = 3;
   localparam int unsigned MASK_W    = 16;
   localparam int unsigned TIMEOUT_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ARMED        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_NS   = 2'd2;

   // Timeout after reset: twenty milliseconds.
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd20_000_000;

   // Outcome codes of one result transaction.
   localparam logic [OUTCOME_W-1:0] OUT_DISARMED      = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_UNKNOWN       = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_DEAD_ALREADY  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_REFRESHED     = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_SILENT_OK     = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_DECLARED_DEAD = 3'd5;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [MASK_W-1:0]    channel_mask;
      logic                 armed;
      logic [TIMEOUT_W-1:0] timeout_ns;
   } cfg_type;

   // One channel entry of the state memory.
   typedef struct packed {
      logic               alive;
      logic [STAMP_W-1:0] last_good;
   } entry_type;

endpackage

// ===== src/rlw_csr.sv =====
// ----------------------------------------------------------------------------
// Rotor link watchdog configuration registers
// Holds the channel mask, the arm flag and the timeout; writes to an index
// beyond the register list are dropped.
// ----------------------------------------------------------------------------
module rlw_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [rlw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlw_pkg::CSR_DAT_W-1:0]  csr_write_data,
   output rlw_pkg::cfg_type               cfg
);

   rlw_pkg::cfg_type cfg_ff;
   rlw_pkg::cfg_type cfg_in;

   // Decode the write and keep the other fields.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rlw_pkg::REG_CHANNEL_MASK: begin
               cfg_in.channel_mask = csr_write_data[rlw_pkg::MASK_W-1:0];
            end
            rlw_pkg::REG_ARMED: begin
               cfg_in.armed = csr_write_data[0];
            end
            rlw_pkg::REG_TIMEOUT_NS: begin
               cfg_in.timeout_ns = csr_write_data[rlw_pkg::TIMEOUT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_mask <= '0;
         cfg_ff.armed        <= 1'b0;
         cfg_ff.timeout_ns   <= rlw_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/rlw_store.sv =====
// ----------------------------------------------------------------------------
// Rotor link watchdog channel store
// Synchronous memory of one entry per channel with a registered read port
// and a write port. A valid flag per entry makes an unwritten entry read as
// the reset value: alive, last good time zero.
// ----------------------------------------------------------------------------
module rlw_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IDX_W = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output rlw_pkg::entry_type   rd_entry,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  rlw_pkg::entry_type   wr_entry
);

   rlw_pkg::entry_type mem [0:DEPTH-1];
   rlw_pkg::entry_type rd_data_ff;
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic               rd_valid_ff;

   // Memory array: write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // An entry becomes valid on its first write.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry never written reads as the reset value.
   always_comb begin
      if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry.alive     = 1'b1;
         rd_entry.last_good = '0;
      end
   end

endmodule

// ===== src/rotor_link_watchdog.sv =====
// ----------------------------------------------------------------------------
// Timing: the store read and the report fields are registered when a request
// is accepted; the result is registered once the output register is free.
// One report is in evaluation at a time; a new one is stalled until the last
// is evaluated. The store is written back as the result is registered.
// Reset: registers return to their reset values and every channel reads as
// alive with last good time zero at once, with no clearing pass.
// ----------------------------------------------------------------------------
// Rotor link watchdog
// Per-channel communication timeout watchdog: each report reads the channel
// entry, checks the silence against the timeout and writes back any update.
// ----------------------------------------------------------------------------
module rotor_link_watchdog #(
   parameter int unsigned NUM_CHANNELS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration port
   input  logic                                csr_write_enable,
   input  logic [rlw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rlw_pkg::CSR_DAT_W-1:0]       csr_write_data,
   // Report channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rlw_pkg::CHANNEL_W-1:0]       req_rotor_channel,
   input  logic                                req_no_link,
   input  logic [rlw_pkg::STAMP_W-1:0]         req_stamp_ns,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rlw_pkg::CHANNEL_W-1:0]       rsp_echo_channel,
   output logic [rlw_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic                                rsp_disable_now
);

   // Only channels below both the parameter and the mask width are stored.
   localparam int unsigned DEPTH = (NUM_CHANNELS < rlw_pkg::MASK_W) ?
                                   NUM_CHANNELS : rlw_pkg::MASK_W;
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CMP_W = rlw_pkg::CHANNEL_W + 1;

   rlw_pkg::cfg_type   cfg;
   rlw_pkg::entry_type rd_entry;
   rlw_pkg::entry_type wr_entry;

   logic                              req_accept;
   logic [IDX_W-1:0]                  rd_addr;
   logic                              wr_en;
   logic                              busy_ff;
   logic                              busy_in;
   logic                              load;

   logic [rlw_pkg::CHANNEL_W-1:0]     chan_ff;
   logic                              no_link_ff;
   logic [rlw_pkg::STAMP_W-1:0]       stamp_ff;

   logic                              known;
   logic [rlw_pkg::STAMP_W:0]         elapsed;
   logic                              expired;
   logic [rlw_pkg::OUTCOME_W-1:0]     outcome;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [rlw_pkg::CHANNEL_W-1:0]     rsp_channel_ff;
   logic [rlw_pkg::OUTCOME_W-1:0]     rsp_outcome_ff;
   logic                              rsp_disable_ff;

   rlw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // One report in flight at a time; the store read is issued on accept.
   assign req_stall  = busy_ff;
   assign req_accept = req_valid & ~req_stall;

   // Channels outside the store read entry zero; their result ignores it.
   assign rd_addr = ({1'b0, req_rotor_channel} < CMP_W'(DEPTH)) ?
                    req_rotor_channel[IDX_W-1:0] : '0;

   rlw_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (chan_ff[IDX_W-1:0]),
      .wr_entry (wr_entry)
   );

   // Capture the report fields alongside the store read.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         chan_ff    <= req_rotor_channel;
         no_link_ff <= req_no_link;
         stamp_ff   <= req_stamp_ns;
      end
   end

   // Evaluate once the output register can take the transaction.
   assign load    = busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign busy_in = req_accept | (busy_ff & ~load);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Signed silence since the last good report, checked against the timeout.
   assign known   = ({1'b0, chan_ff} < CMP_W'(DEPTH)) &
                    cfg.channel_mask[chan_ff[3:0]];
   assign elapsed = {1'b0, stamp_ff} - {1'b0, rd_entry.last_good};
   assign expired = ~elapsed[rlw_pkg::STAMP_W] &
                    (elapsed[rlw_pkg::STAMP_W-1:0] >
                     {{(rlw_pkg::STAMP_W - rlw_pkg::TIMEOUT_W){1'b0}}, cfg.timeout_ns});

   // Outcome and write-back of the channel entry.
   always_comb begin
      wr_en    = 1'b0;
      wr_entry = rd_entry;
      if (!cfg.armed) begin
         outcome = rlw_pkg::OUT_DISARMED;
      end else if (!known) begin
         outcome = rlw_pkg::OUT_UNKNOWN;
      end else if (!rd_entry.alive) begin
         outcome = rlw_pkg::OUT_DEAD_ALREADY;
      end else if (!no_link_ff) begin
         outcome            = rlw_pkg::OUT_REFRESHED;
         wr_en              = load;
         wr_entry.last_good = stamp_ff;
      end else if (expired) begin
         outcome        = rlw_pkg::OUT_DECLARED_DEAD;
         wr_en          = load;
         wr_entry.alive = 1'b0;
      end else begin
         outcome = rlw_pkg::OUT_SILENT_OK;
      end
   end

   // Output register parts the result channel from the report channel.
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_channel_ff <= chan_ff;
         rsp_outcome_ff <= outcome;
         rsp_disable_ff <= (outcome == rlw_pkg::OUT_DECLARED_DEAD);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_echo_channel = rsp_channel_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_disable_now  = rsp_disable_ff;

   // A report accepted is in evaluation on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("accepted report not in evaluation");

   // Store writes only happen while the result is being registered.
   a_write_with_load: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (load && cfg.armed && known))
      else $error("store written without a result");

   // A write-back always yields a refresh or a declared-dead result.
   a_write_outcome: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_valid && (rsp_outcome == rlw_pkg::OUT_REFRESHED ||
                               rsp_outcome == rlw_pkg::OUT_DECLARED_DEAD)))
      else $error("write-back with wrong outcome");

   // The disable request matches the declared-dead outcome.
   a_disable_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_disable_now == (rsp_outcome == rlw_pkg::OUT_DECLARED_DEAD)))
      else $error("disable request does not match outcome");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Rotor link watchdog testbench
// Drives status reports through the watchdog and predicts every result from
// its own copy of the channel state and the registers. Directed reports reach
// the timeout boundaries, stale timestamps and mask changes first. Random
// phases under several register settings follow. Reports come with random
// gaps and results see random stalls, except in one quiet phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CHANNELS = 16;
   // The configuration port decodes a fourth index that maps to no register.
   localparam logic [rlw_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [rlw_pkg::STAMP_W-1:0]   STAMP_MAX  = {rlw_pkg::STAMP_W{1'b1}};

   // One expected result transaction.
   typedef struct packed {
      logic [rlw_pkg::CHANNEL_W-1:0] channel;
      logic [rlw_pkg::OUTCOME_W-1:0] outcome;
      logic                          disable_now;
   } verdict_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [rlw_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [rlw_pkg::CSR_DAT_W-1:0]   csr_write_data = '0;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [rlw_pkg::CHANNEL_W-1:0]   req_rotor_channel = '0;
   logic                            req_no_link = 1'b0;
   logic [rlw_pkg::STAMP_W-1:0]     req_stamp_ns = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [rlw_pkg::CHANNEL_W-1:0]   rsp_echo_channel;
   logic [rlw_pkg::OUTCOME_W-1:0]   rsp_outcome;
   logic                            rsp_disable_now;

   // Set during the stretch in which neither side idles.
   bit quiet = 1'b0;

   // Predicts each verdict and checks the results against them in order.
   class watchdog_scoreboard;
      logic [rlw_pkg::MASK_W-1:0]    channel_mask;
      logic                          armed;
      logic [rlw_pkg::TIMEOUT_W-1:0] timeout_ns;
      logic                          alive [CHANNELS];
      logic [rlw_pkg::STAMP_W-1:0]   last_good [CHANNELS];
      verdict_type                   pending_verdicts [$];
      int unsigned                   tally [6];
      int unsigned                   failures;
      int unsigned                   writes;

      function new();
         channel_mask = '0;
         armed        = 1'b0;
         timeout_ns   = rlw_pkg::TIMEOUT_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            alive[c]     = 1'b1;
            last_good[c] = '0;
         end
         foreach (tally[i]) tally[i] = 0;
         failures = 0;
         writes   = 0;
      endfunction

      function void set_register(input logic [rlw_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [rlw_pkg::CSR_DAT_W-1:0] data);
         case (idx)
            rlw_pkg::REG_CHANNEL_MASK: channel_mask = data[rlw_pkg::MASK_W-1:0];
            rlw_pkg::REG_ARMED:        armed        = data[0];
            rlw_pkg::REG_TIMEOUT_NS:   timeout_ns   = data[rlw_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
         writes++;
      endfunction

      // Works out the verdict of one accepted report and updates the state.
      function void note_report(input logic [rlw_pkg::CHANNEL_W-1:0] ch,
                                input logic no_link,
                                input logic [rlw_pkg::STAMP_W-1:0] stamp);
         verdict_type        v;
         logic signed [63:0] elapsed;
         int unsigned        idx;
         idx           = {24'd0, ch};
         v.channel     = ch;
         v.disable_now = 1'b0;
         if (!armed) begin
            v.outcome = rlw_pkg::OUT_DISARMED;
         end else if (idx >= CHANNELS) begin
            v.outcome = rlw_pkg::OUT_UNKNOWN;
         end else if (!channel_mask[idx]) begin
            v.outcome = rlw_pkg::OUT_UNKNOWN;
         end else if (!alive[idx]) begin
            v.outcome = rlw_pkg::OUT_DEAD_ALREADY;
         end else if (!no_link) begin
            last_good[idx] = stamp;
            v.outcome      = rlw_pkg::OUT_REFRESHED;
         end else begin
            // A stale timestamp gives a negative silence, which never times out.
            elapsed = $signed({1'b0, stamp}) - $signed({1'b0, last_good[idx]});
            if (elapsed > $signed({32'd0, timeout_ns})) begin
               alive[idx]    = 1'b0;
               v.outcome     = rlw_pkg::OUT_DECLARED_DEAD;
               v.disable_now = 1'b1;
            end else begin
               v.outcome = rlw_pkg::OUT_SILENT_OK;
            end
         end
         pending_verdicts.push_back(v);
         tally[v.outcome]++;
      endfunction

      function void check_result(input logic [rlw_pkg::CHANNEL_W-1:0] ch,
                                 input logic [rlw_pkg::OUTCOME_W-1:0] outcome,
                                 input logic disable_now);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            $error("result transaction for channel %0d with no report outstanding", ch);
            failures++;
            return;
         end
         v = pending_verdicts.pop_front();
         if (ch !== v.channel) begin
            $error("echo_channel mismatch: expected %0d, actual %0d", v.channel, ch);
            failures++;
         end
         if (outcome !== v.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", v.outcome, outcome);
            failures++;
         end
         if (disable_now !== v.disable_now) begin
            $error("disable_now mismatch: expected %0d, actual %0d",
                   v.disable_now, disable_now);
            failures++;
         end
      endfunction
   endclass

   watchdog_scoreboard sb = new();

   rotor_link_watchdog #(
      .NUM_CHANNELS(CHANNELS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rotor_channel (req_rotor_channel),
      .req_no_link       (req_no_link),
      .req_stamp_ns      (req_stamp_ns),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_echo_channel  (rsp_echo_channel),
      .rsp_outcome       (rsp_outcome),
      .rsp_disable_now   (rsp_disable_now)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side stalls at random outside the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 21);
   end

   // Both handshakes are observed at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_report(req_rotor_channel, req_no_link, req_stamp_ns);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_echo_channel, rsp_outcome, rsp_disable_now);
      end
   end

   // Presents one report, holds it until accepted, then idles at random.
   task automatic send_report(input logic [rlw_pkg::CHANNEL_W-1:0] ch,
                              input logic no_link,
                              input logic [rlw_pkg::STAMP_W-1:0] stamp);
      req_valid         <= 1'b1;
      req_rotor_channel <= ch;
      req_no_link       <= no_link;
      req_stamp_ns      <= stamp;
      do @(posedge clock); while (req_stall);
      if (!quiet && ($urandom_range(0, 99) < 21)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Waits until every expected result has been accepted.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rlw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rlw_pkg::CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [rlw_pkg::CSR_DAT_W-1:0] mask,
                            input logic [rlw_pkg::CSR_DAT_W-1:0] arm,
                            input logic [rlw_pkg::CSR_DAT_W-1:0] timeout);
      settle();
      write_reg(rlw_pkg::REG_CHANNEL_MASK, mask);
      write_reg(rlw_pkg::REG_ARMED, arm);
      write_reg(rlw_pkg::REG_TIMEOUT_NS, timeout);
   endtask

   // Mostly plausible report streams built on the predicted last good time,
   // with a little noise, some unknown channels and rare deliberate deaths.
   task automatic random_report();
      int unsigned                   pick;
      logic [31:0]                   ch_draw;
      logic [rlw_pkg::CHANNEL_W-1:0] ch;
      logic                          no_link;
      logic [rlw_pkg::STAMP_W-1:0]   base;
      logic [rlw_pkg::STAMP_W-1:0]   stamp;
      logic [63:0]                   span;
      logic [63:0]                   draw;
      logic [63:0]                   offset;
      pick = $urandom_range(0, 999);
      if ($urandom_range(0, 99) < 88) ch_draw = $urandom_range(0, CHANNELS - 1);
      else ch_draw = $urandom_range(CHANNELS, 255);
      ch      = ch_draw[rlw_pkg::CHANNEL_W-1:0];
      base    = sb.last_good[ch[3:0]];
      span    = {32'd0, sb.timeout_ns} + 64'd1;
      draw    = {$urandom, $urandom};
      offset  = draw % span;
      no_link = 1'b1;
      if (pick < 600) begin
         no_link = 1'b0;
         offset  = offset >> 1;
         stamp   = base + offset[rlw_pkg::STAMP_W-1:0];
      end else if (pick < 900) begin
         stamp = base + offset[rlw_pkg::STAMP_W-1:0];
      end else if (pick < 950) begin
         if (base > 1000) stamp = base - {31'd0, $urandom_range(1, 1000)};
         else stamp = base;
      end else if (pick < 958) begin
         stamp = base + {31'd0, sb.timeout_ns} + {31'd0, $urandom_range(1, 50)};
      end else begin
         stamp   = draw[rlw_pkg::STAMP_W-1:0];
         no_link = ($urandom_range(0, 3) == 0);
      end
      send_report(ch, no_link, stamp);
   endtask

   // Runs a fixed number of random reports.
   task automatic run_phase(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         random_report();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Disarmed after reset: everything is ignored.
      send_report(8'd0, 1'b0, '0);
      send_report(8'd255, 1'b1, STAMP_MAX);
      settle();
      write_reg(rlw_pkg::REG_CHANNEL_MASK, 32'hFFFF_FFFF);
      write_reg(rlw_pkg::REG_ARMED, 32'h0000_0001);

      // Reset timeout: a silence equal to it survives, one more nanosecond does not.
      send_report(8'd0, 1'b1, 63'd20_000_000);
      send_report(8'd0, 1'b1, 63'd20_000_001);
      send_report(8'd0, 1'b0, 63'd7);
      // Channels beyond the table.
      send_report(8'd16, 1'b0, 63'd1);
      send_report(8'd255, 1'b1, STAMP_MAX);
      // Stale timestamps never time out; a fresh one past the timeout still does.
      send_report(8'd1, 1'b0, 63'd1000);
      send_report(8'd1, 1'b1, 63'd500);
      send_report(8'd1, 1'b1, 63'd20_001_001);
      send_report(8'd2, 1'b0, STAMP_MAX);
      send_report(8'd2, 1'b1, '0);

      // Zero timeout.
      settle();
      write_reg(rlw_pkg::REG_TIMEOUT_NS, 32'd0);
      send_report(8'd3, 1'b0, 63'd100);
      send_report(8'd3, 1'b1, 63'd100);
      send_report(8'd3, 1'b1, 63'd101);

      // Largest timeout.
      settle();
      write_reg(rlw_pkg::REG_TIMEOUT_NS, 32'hFFFF_FFFF);
      send_report(8'd4, 1'b0, '0);
      send_report(8'd4, 1'b1, 63'h0_FFFF_FFFF);
      send_report(8'd4, 1'b1, 63'h1_0000_0000);

      // Removing channels from the mask; the spare index changes nothing.
      settle();
      write_reg(rlw_pkg::REG_CHANNEL_MASK, 32'hA5A5_FFDE);
      write_reg(REG_UNUSED, 32'h0000_0000);
      send_report(8'd5, 1'b0, 63'd10);
      send_report(8'd0, 1'b0, 63'd10);
      send_report(8'd15, 1'b0, 63'd10);

      // Re-enabled channels keep their old state.
      settle();
      write_reg(rlw_pkg::REG_CHANNEL_MASK, 32'h0000_FFFF);
      send_report(8'd0, 1'b0, 63'd10);
      send_report(8'd5, 1'b0, 63'd10);

      // Disarm through bit zero alone.
      settle();
      write_reg(rlw_pkg::REG_ARMED, 32'hFFFF_FFFE);
      send_report(8'd6, 1'b1, STAMP_MAX);

      // Random phases under varied settings.
      configure(32'h0000_FFFF, 32'h0000_0001, $urandom_range(1000, 5_000_000));
      run_phase(250);
      configure($urandom, $urandom | 32'h1, $urandom_range(0, 20));
      run_phase(200);
      configure(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      quiet = 1'b1;
      run_phase(250);
      quiet = 1'b0;
      configure($urandom, $urandom & 32'hFFFF_FFFE, $urandom);
      run_phase(15);
      configure($urandom | 32'h0000_0F0F, 32'h0000_0001, 32'd0);
      run_phase(150);
      configure(32'h0000_FFFF, 32'h0000_0001, $urandom);
      run_phase(200);

      settle();
      repeat (10) @(posedge clock);

      $display("Covered %0d reports over %0d register writes: %0d disarmed, %0d unknown,",
               sb.tally[0] + sb.tally[1] + sb.tally[2] + sb.tally[3] + sb.tally[4]
               + sb.tally[5], sb.writes, sb.tally[rlw_pkg::OUT_DISARMED],
               sb.tally[rlw_pkg::OUT_UNKNOWN]);
      $display("%0d already dead, %0d refreshed, %0d silent in time, %0d declared dead.",
               sb.tally[rlw_pkg::OUT_DEAD_ALREADY], sb.tally[rlw_pkg::OUT_REFRESHED],
               sb.tally[rlw_pkg::OUT_SILENT_OK], sb.tally[rlw_pkg::OUT_DECLARED_DEAD]);
      if (sb.failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
